FILE: rtl/substring_first_match_finder_core_assert.svh
// Assertion macros used by the checker of the substring finder.
`ifndef SUBSTRING_FIRST_MATCH_FINDER_CORE_ASSERT_SVH
`define SUBSTRING_FIRST_MATCH_FINDER_CORE_ASSERT_SVH

// Property checked on every rising edge, switched off while reset is asserted.
`define SFMF_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define SFMF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/sfmf_pkg.sv
// ----------------------------------------------------------------------------
// sfmf_pkg
// Types and constants shared by the substring first-match finder modules.
// ----------------------------------------------------------------------------
package sfmf_pkg;

  localparam int MAX_PATTERN   = 16;
  localparam int PATTERN_BYTES = 16;
  localparam int PATTERN_BITS  = 8 * PATTERN_BYTES;
  localparam int LEN_W         = 5;
  localparam int COUNT_W       = 32;
  localparam int APB_ADDR_W    = 5;
  localparam int APB_DATA_W    = 64;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] REG_PATTERN_LOW    = 2'd1;
  localparam logic [1:0] REG_PATTERN_HIGH   = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } sfmf_text_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] position;
  } sfmf_result_t;

  typedef struct packed {
    logic [LEN_W-1:0]        pattern_length;
    logic [PATTERN_BITS-1:0] pattern_bytes;
  } sfmf_cfg_t;

endpackage

FILE: rtl/sfmf_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfmf_cfg_regs
// APB register file holding the pattern length and the sixteen pattern bytes.
// ----------------------------------------------------------------------------
module sfmf_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sfmf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [sfmf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [sfmf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output sfmf_pkg::sfmf_cfg_t                cfg_o
);

  logic [sfmf_pkg::LEN_W-1:0]      len_q;
  logic [sfmf_pkg::APB_DATA_W-1:0] low_q;
  logic [sfmf_pkg::APB_DATA_W-1:0] high_q;
  logic [1:0]                      reg_idx;
  logic                            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      low_q  <= '0;
      high_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        sfmf_pkg::REG_PATTERN_LENGTH: begin
          len_q <= pwdata[sfmf_pkg::LEN_W-1:0];
        end
        sfmf_pkg::REG_PATTERN_LOW: begin
          low_q <= pwdata;
        end
        sfmf_pkg::REG_PATTERN_HIGH: begin
          high_q <= pwdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfmf_pkg::REG_PATTERN_LENGTH: begin
        prdata = {{(sfmf_pkg::APB_DATA_W-sfmf_pkg::LEN_W){1'b0}}, len_q};
      end
      sfmf_pkg::REG_PATTERN_LOW: begin
        prdata = low_q;
      end
      sfmf_pkg::REG_PATTERN_HIGH: begin
        prdata = high_q;
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign cfg_o.pattern_length = len_q;
  assign cfg_o.pattern_bytes  = {high_q, low_q};

endmodule

FILE: rtl/sfmf_cell.sv
// ----------------------------------------------------------------------------
// sfmf_cell
// One window position: holds a text byte, passes it on, and checks the byte
// that moves in against the pattern byte aligned to this position.
// ----------------------------------------------------------------------------
module sfmf_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_en_i,
  input  logic                clear_i,
  input  logic [7:0]          byte_i,
  input  sfmf_pkg::sfmf_cfg_t cfg_i,
  output logic [7:0]          byte_o,
  output logic                hit_o
);

  localparam logic [6:0] Idx = 7'(CELL_INDEX);

  logic [7:0] byte_q;
  logic [6:0] len_ext;
  logic [6:0] pat_idx;
  logic       active;
  logic [7:0] expected;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (clear_i) begin
      byte_q <= '0;
    end else if (shift_en_i) begin
      byte_q <= byte_i;
    end
  end

  // The newest byte sits in cell 0, so this cell meets pattern byte len-1-index.
  always_comb begin
    len_ext = {2'b00, cfg_i.pattern_length};
    active  = Idx < len_ext;
    pat_idx = len_ext - Idx - 7'd1;
    if (pat_idx < 7'(sfmf_pkg::PATTERN_BYTES)) begin
      expected = cfg_i.pattern_bytes[{pat_idx[3:0], 3'b000} +: 8];
    end else begin
      expected = '0;
    end
  end

  assign hit_o  = !active || (byte_i == expected);
  assign byte_o = byte_q;

endmodule

FILE: rtl/substring_first_match_finder_core.sv
// ----------------------------------------------------------------------------
// substring_first_match_finder_core: first occurrence of a pattern in a text.
// Result: registered in the output register from the accepted request that produces it.
// Throughput: one text byte per cycle while in_ready_o is high; the cell row compares combinationally.
// Reset: asynchronous; window, count, matched flag and output valid clear, the payload does not.
// ----------------------------------------------------------------------------
module substring_first_match_finder_core #(
  parameter int MAX_PATTERN = sfmf_pkg::MAX_PATTERN
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Text request channel.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sfmf_pkg::sfmf_text_req_t         in_req_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output sfmf_pkg::sfmf_result_t           out_rsp_o,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfmf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sfmf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sfmf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int CW = sfmf_pkg::COUNT_W;

  sfmf_pkg::sfmf_cfg_t    cfg;
  logic                   in_fire;
  logic                   last_byte;
  logic [7:0]             chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_hit;
  logic                   window_hit;
  logic                   len_ok;
  logic [CW-1:0]          len_ext;
  logic [CW-1:0]          bytes_seen_q, bytes_seen_d, bytes_next;
  logic                   matched_q, matched_d;
  logic                   match;
  logic                   emit;
  logic                   out_valid_q, out_valid_d;
  sfmf_pkg::sfmf_result_t out_rsp_q, out_rsp_d;

  // Configuration registers.
  sfmf_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The output register decouples the two sides: a new request is taken
  // whenever the register is empty or its result leaves in this same cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_byte  = in_req_i.end_of_text;

  // The window is a row of cells. Each accepted byte enters cell 0 and every
  // cell hands its byte to the next one. Each cell compares the byte moving
  // into it with its pattern byte, so the row sees the window as it stands
  // after this byte, before the byte is registered.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [7:0] cell_in;
    if (j == 0) begin : g_head
      assign cell_in = in_req_i.text_byte;
    end else begin : g_body
      assign cell_in = chain[j-1];
    end

    sfmf_cell #(
      .CELL_INDEX (j)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (in_fire),
      .clear_i    (in_fire && last_byte),
      .byte_i     (cell_in),
      .cfg_i      (cfg),
      .byte_o     (chain[j]),
      .hit_o      (cell_hit[j])
    );
  end

  // Cells beyond the pattern length report a hit, so the AND covers only the
  // live part of the window.
  assign window_hit = &cell_hit;

  // An empty pattern, or one longer than the window, never matches.
  assign len_ok  = (cfg.pattern_length != '0) &&
                   ({2'b00, cfg.pattern_length} <= 7'(MAX_PATTERN));
  assign len_ext = {{(CW-sfmf_pkg::LEN_W){1'b0}}, cfg.pattern_length};

  // The byte count stops at its top value instead of wrapping.
  assign bytes_next = (&bytes_seen_q) ? bytes_seen_q : bytes_seen_q + 1'b1;

  // A match needs enough bytes seen to fill the pattern, and only the first
  // match of a text is reported.
  assign match = !matched_q && len_ok && (bytes_next >= len_ext) && window_hit;

  // A result leaves on a match, or on the final byte of a text that never
  // matched.
  assign emit = match || (last_byte && !matched_q);

  always_comb begin
    bytes_seen_d = bytes_seen_q;
    matched_d    = matched_q;
    if (in_fire) begin
      if (last_byte) begin
        // The stream state returns to its reset values after the final byte.
        bytes_seen_d = '0;
        matched_d    = 1'b0;
      end else begin
        bytes_seen_d = bytes_next;
        matched_d    = matched_q || match;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && emit) begin
      out_valid_d        = 1'b1;
      out_rsp_d.found    = match;
      out_rsp_d.position = match ? (bytes_next - len_ext) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      matched_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      bytes_seen_q <= bytes_seen_d;
      matched_q    <= matched_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // The result payload needs no reset; it is only read while valid is high.
  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

FILE: rtl/sfmf_checker.sv
// ----------------------------------------------------------------------------
// sfmf_checker
// Port-level checks of the substring first-match finder, bound to its top.
// ----------------------------------------------------------------------------
`include "substring_first_match_finder_core_assert.svh"

module sfmf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input sfmf_pkg::sfmf_text_req_t         in_req_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input sfmf_pkg::sfmf_result_t           out_rsp_o,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [sfmf_pkg::APB_ADDR_W-1:0]  paddr,
  input logic [sfmf_pkg::APB_DATA_W-1:0]  pwdata,
  input logic [sfmf_pkg::APB_DATA_W-1:0]  prdata,
  input logic                             pready
);

  // A stalled result holds until it is taken.
  `SFMF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o), "result changed while stalled")

  // A not-found result always carries position zero.
  `SFMF_ASSERT(a_notfound_pos, clk_i, rst_ni, out_valid_o && !out_rsp_o.found |-> out_rsp_o.position == '0, "not-found result with nonzero position")

  // With the output register empty, the block must take requests.
  `SFMF_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "not ready while output is empty")

  // A new result only follows an accepted request.
  `SFMF_ASSERT(a_result_cause, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o), "result without a request")

  // The register port never inserts wait states.
  `SFMF_ASSERT_ALWAYS(a_pready_high, clk_i, pready, "pready went low")

endmodule

bind substring_first_match_finder_core sfmf_checker u_sfmf_checker (.*);
